[src/mlb_pkg.sv]
// Shared types and constants for the multichannel lowpass biquad.
package mlb_pkg;

  // Fixed field widths.
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned COEF_FRAC = 22;
  localparam int unsigned CFG_IDX_W = 2;

  // Action codes of an input transaction.
  localparam logic ACTION_FILTER = 1'b0;
  localparam logic ACTION_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 2'd2;

  // Coefficient reset values (4 kHz cutoff at 44.1 kHz, Q2.22).
  localparam logic signed [COEF_W-1:0] COEF_A0_RST = 24'sd239956;
  localparam logic signed [COEF_W-1:0] COEF_B1_RST = -24'sd5111600;
  localparam logic signed [COEF_W-1:0] COEF_B2_RST = 24'sd1877370;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TAIL,
    ST_ROUND,
    ST_DONE
  } state_e;

  // Product term selected for the shared multiplier.
  typedef enum logic [2:0] {
    TERM_X,
    TERM_X1,
    TERM_X2,
    TERM_Y1,
    TERM_Y2
  } term_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  issue_read;
    logic  clear_hist;
    logic  mul_en;
    term_e term;
    logic  acc_en;
    logic  acc_load;
    logic  round_en;
    logic  commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chan_ok;
    logic out_free;
  } status_t;

endpackage

[src/mlb_intf.sv]
// Channel interfaces of the multichannel lowpass biquad: samples, results and configuration.
interface mlb_smp_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [2:0]                    channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, action, channel, sample_in, input ready);
  modport sink (input valid, action, channel, sample_in, output ready);
endinterface

interface mlb_res_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    channel_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface mlb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/mlb_ctrl.sv]
// Controller state machine sequencing the shared multiply-accumulate of the biquad.
module mlb_ctrl
  import mlb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_action_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  localparam logic [2:0] LAST_TERM = 3'(TERM_Y2);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  // State and term counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.term = term_e'(cnt_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          if (in_action_i == ACTION_CLEAR) begin
            cmd_o.clear_hist = 1'b1;
          end else if (status_i.chan_ok) begin
            cmd_o.issue_read = 1'b1;
            state_d          = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // One product per cycle; the previous product is summed meanwhile.
        cmd_o.mul_en   = 1'b1;
        cmd_o.acc_en   = (cnt_q != 3'd0);
        cmd_o.acc_load = (cnt_q == 3'd1);
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == LAST_TERM) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // Write the histories back once the output register can take the result.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/mlb_datapath.sv]
// Datapath of the biquad: coefficients, history memory, shared multiplier, rounding and output.
module mlb_datapath
  import mlb_pkg::*;
#(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  input  logic [CHAN_W-1:0]             in_channel_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COEF_W-1:0]             cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [CHAN_W-1:0]             out_channel_o,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o
);

  localparam int unsigned IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CMP_W   = 9;
  localparam int unsigned HIST_W  = 4 * SAMPLE_BITS;
  localparam int unsigned MCOEF_W = COEF_W + 1;
  localparam int unsigned PROD_W  = SAMPLE_BITS + MCOEF_W;
  localparam int unsigned ACC_W   = SAMPLE_BITS + COEF_W + 3;
  localparam int unsigned SH_W    = ACC_W - COEF_FRAC;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [SH_W-1:0]  SAT_HI   =
    {{(SH_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SH_W-1:0]  SAT_LO   = ~SAT_HI;

  // Coefficient registers.
  logic signed [COEF_W-1:0] a0_q, b1_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q <= COEF_A0_RST;
      b1_q <= COEF_B1_RST;
      b2_q <= COEF_B2_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_A0: a0_q <= cfg_data_i;
        REG_COEF_B1: b1_q <= cfg_data_i;
        REG_COEF_B2: b2_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Channel range check and memory index.
  logic [CMP_W-1:0] chan_ext;
  logic [IDX_W-1:0] rd_idx;

  assign chan_ext = CMP_W'(in_channel_i);
  assign rd_idx   = chan_ext[IDX_W-1:0];

  // History memory, one row per channel: previous and older input and output.
  logic [HIST_W-1:0]          hist_mem [CHANNELS];
  logic [HIST_W-1:0]          rd_q;
  logic                       rd_vld_q;
  logic [CHANNELS-1:0]        hist_vld_q;
  logic [IDX_W-1:0]           idx_q;
  logic [CHAN_W-1:0]          chan_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [SAMPLE_BITS-1:0] rd_x1, rd_x2, rd_y1, rd_y2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hist_mem[idx_q] <= {x_q, rd_x1, y_q, rd_y1};
    end
    if (cmd_i.issue_read) begin
      rd_q   <= hist_mem[rd_idx];
      idx_q  <= rd_idx;
      chan_q <= in_channel_i;
      x_q    <= in_sample_i;
    end
  end

  // Row valid bits: a row that is not valid reads as zero histories.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_hist) begin
        hist_vld_q <= '0;
      end else if (cmd_i.commit) begin
        hist_vld_q[idx_q] <= 1'b1;
      end
      if (cmd_i.issue_read) begin
        rd_vld_q <= hist_vld_q[rd_idx];
      end
    end
  end

  assign rd_x1 = rd_vld_q ? rd_q[4*SAMPLE_BITS-1:3*SAMPLE_BITS] : '0;
  assign rd_x2 = rd_vld_q ? rd_q[3*SAMPLE_BITS-1:2*SAMPLE_BITS] : '0;
  assign rd_y1 = rd_vld_q ? rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS]   : '0;
  assign rd_y2 = rd_vld_q ? rd_q[SAMPLE_BITS-1:0]               : '0;

  // Operand and coefficient selection for the current term.
  logic signed [MCOEF_W-1:0]     mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_op;

  always_comb begin
    case (cmd_i.term)
      TERM_X: begin
        mul_coef = MCOEF_W'(a0_q);
        mul_op   = x_q;
      end
      TERM_X1: begin
        mul_coef = {a0_q, 1'b0};
        mul_op   = rd_x1;
      end
      TERM_X2: begin
        mul_coef = MCOEF_W'(a0_q);
        mul_op   = rd_x2;
      end
      TERM_Y1: begin
        mul_coef = -MCOEF_W'(b1_q);
        mul_op   = rd_y1;
      end
      TERM_Y2: begin
        mul_coef = -MCOEF_W'(b2_q);
        mul_op   = rd_y2;
      end
      default: begin
        mul_coef = '0;
        mul_op   = '0;
      end
    endcase
  end

  // Shared multiplier followed by the accumulator.
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_coef * mul_op;
    end
    if (cmd_i.acc_en) begin
      if (cmd_i.acc_load) begin
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Round half up to the sample format, then saturate.
  logic signed [ACC_W-1:0]       acc_rnd;
  logic signed [SH_W-1:0]        acc_sh;
  logic signed [SAMPLE_BITS-1:0] y_d;

  assign acc_rnd = acc_q + HALF_LSB;
  assign acc_sh  = acc_rnd[ACC_W-1:COEF_FRAC];

  always_comb begin
    if (acc_sh > SAT_HI) begin
      y_d = SAT_HI[SAMPLE_BITS-1:0];
    end else if (acc_sh < SAT_LO) begin
      y_d = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_d = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      y_q <= y_d;
    end
  end

  // Output register: holds a finished result while the next transaction is taken.
  logic                          out_vld_q;
  logic [CHAN_W-1:0]             out_chan_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_chan_q <= chan_q;
      out_smp_q  <= y_q;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_channel_o     = out_chan_q;
  assign out_sample_o      = out_smp_q;
  assign status_o.chan_ok  = (chan_ext < CMP_W'(CHANNELS));
  assign status_o.out_free = !out_vld_q || out_ready_i;

endmodule

[src/multichannel_lowpass_biquad_top.sv]
// Top level of the multichannel second-order Butterworth lowpass biquad.
//
// Usage: sample_i takes transactions that either filter one sample on one channel
// (action filter) or clear the histories of every channel (action clear). Each
// filtered sample yields one transaction on result_o with its channel; a clear,
// or a sample whose channel is not below CHANNELS, yields none. cfg_i writes the
// three Q2.22 coefficients a0, b1 and b2; it is always ready, and a write to an
// index beyond them is ignored. Write coefficients only while the block is idle.
// A sample is accepted only while the block is idle. The history read, the five
// products formed one per cycle by the single shared multiplier, the rounding and
// the write-back then follow in order before the next sample can be taken. A clear
// or an ignored sample leaves the block idle and ready for the next transaction.
// Reset sets the coefficients to a 4 kHz cutoff at 44.1 kHz and marks every
// channel history as zero; a clear does so for the histories only. When the receiver
// stalls, the result waits in the output register and one further sample is still
// accepted; that sample then waits for the output register before write-back.
module multichannel_lowpass_biquad_top
  import mlb_pkg::*;
#(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mlb_smp_if.sink   sample_i,
  mlb_res_if.source result_o,
  mlb_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  mlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_action_i(sample_i.action),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  mlb_datapath #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_channel_i (sample_i.channel),
    .in_sample_i  (sample_i.sample_in),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_channel_o(result_o.channel_out),
    .out_sample_o (result_o.sample_out)
  );

  assign sample_i.ready = in_ready;
  assign cfg_i.ready    = 1'b1;

endmodule

[src/mlb_checker.sv]
// Port-level assertions for the multichannel lowpass biquad and their binding.
module mlb_checker
  import mlb_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_action_i,
  input logic [CHAN_W-1:0] in_channel_i,
  input logic              out_valid_i,
  input logic              out_ready_i
);

  logic in_acc;
  logic chan_in_range;

  assign in_acc        = in_valid_i && in_ready_i;
  assign chan_in_range = ({6'b0, in_channel_i} < 9'(CHANNELS));

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // After a clear the block is ready again in the next cycle and produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ACTION_CLEAR) |=> in_ready_i && !$rose(out_valid_i))
    else $error("clear transaction misbehaved");

  // A filtered sample with a channel in range leaves the input not ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i == ACTION_FILTER) && chan_in_range |=> !in_ready_i)
    else $error("input accepted while a sample is in progress");

  // A new result only appears at the end of a sample in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while the block was idle");

endmodule

bind multichannel_lowpass_biquad_top mlb_checker #(
  .CHANNELS(CHANNELS)
) u_mlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_action_i (sample_i.action),
  .in_channel_i(sample_i.channel),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready)
);
